// ----- src/alu8mf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8mf_pkg - shared types for the 8-bit ALU with minifloat add
// Operation codes, controller states and the controller-to-datapath command.
// ----------------------------------------------------------------------------
package alu8mf_pkg;

	localparam int unsigned DATA_W  = 8;
	localparam int unsigned IDX_IN_W = 4;
	localparam int unsigned OP_W    = 3;
	localparam int unsigned CNT_W   = 4;

	// Minifloat sum: magnitudes up to 15 << 7, so two of them fit 12 bits
	localparam int unsigned FMAG_W  = 12;
	localparam int unsigned FSUM_W  = FMAG_W + 1;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD = 3'd0,
		OP_ADD  = 3'd1,
		OP_FADD = 3'd2,
		OP_OR   = 3'd3,
		OP_AND  = 3'd4,
		OP_XOR  = 3'd5,
		OP_ROT  = 3'd6,
		OP_READ = 3'd7
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ALU,
		ST_WB
	} state_t;

	// Controller commands to the datapath
	typedef struct packed {
		logic capture;  // latch the beat and read the operand registers
		logic alu;      // register the operation result
		logic wb;       // normalise, write back and load the output register
	} cmd_t;

endpackage

// ----- src/alu8mf_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8mf_in_if - instruction channel
// Valid/ready channel carrying one instruction beat.
// ----------------------------------------------------------------------------
interface alu8mf_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] operation;
	logic [3:0] dest_reg;
	logic [3:0] src_a_reg;
	logic [3:0] src_b_reg;
	logic [3:0] rotate_count;
	logic [7:0] load_value;

	modport source (
		output valid, operation, dest_reg, src_a_reg, src_b_reg, rotate_count,
			load_value,
		input  ready
	);

	modport sink (
		input  valid, operation, dest_reg, src_a_reg, src_b_reg, rotate_count,
			load_value,
		output ready
	);
endinterface

// ----- src/alu8mf_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8mf_out_if - result channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface alu8mf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_value;
	logic       overflow;

	modport source (
		output valid, result_value, overflow,
		input  ready
	);

	modport sink (
		input  valid, result_value, overflow,
		output ready
	);
endinterface

// ----- src/eight_bit_alu_with_minifloat_add.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_alu_with_minifloat_add - execute unit of a small 8-bit machine
// Sixteen-entry register file with load, read, integer add, minifloat add,
// OR, AND, XOR and rotate right.
//
//   channel   dir   handshake      beat contents
//   in_ch     in    valid/ready    operation, dest_reg, src_a_reg, src_b_reg,
//                                  rotate_count, load_value
//   out_ch    out   valid/ready    result_value, overflow
//
// An instruction steps through register-file read, ALU, then normalise and
// write back, sequenced by the controller; the next beat is taken only once
// the controller is back in idle. The result sits in an output register, so a new
// beat is taken while a result waits, in the cycle that result is taken at
// the earliest. Reset clears the register-file valid bits, so all registers
// read zero at once. A stalled output holds the unit idle.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_minifloat_add #(
	parameter int unsigned REGISTER_COUNT = 16
) (
	input  logic  clk,
	input  logic  arst_n,
	alu8mf_in_if.sink    in_ch,
	alu8mf_out_if.source out_ch
);
	import alu8mf_pkg::*;

	cmd_t cmd;

	alu8mf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	alu8mf_dp #(
		.REGISTER_COUNT (REGISTER_COUNT)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.operation    (in_ch.operation),
		.dest_reg     (in_ch.dest_reg),
		.src_a_reg    (in_ch.src_a_reg),
		.src_b_reg    (in_ch.src_b_reg),
		.rotate_count (in_ch.rotate_count),
		.load_value   (in_ch.load_value),
		.result_value (out_ch.result_value),
		.overflow     (out_ch.overflow)
	);

endmodule

// ----- src/alu8mf_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8mf_ctrl - sequencing controller
// Steps each instruction through capture, ALU and write-back, and owns the
// handshake flags of both channels.
// ----------------------------------------------------------------------------
module alu8mf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output alu8mf_pkg::cmd_t  cmd
);
	import alu8mf_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   accept;

	// Take a new beat only when idle and the output register is free by the edge
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.capture = accept;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_ALU;
				end
			end
			ST_ALU: begin
				cmd.alu = 1'b1;
				state_d = ST_WB;
			end
			ST_WB: begin
				cmd.wb  = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.wb) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- src/alu8mf_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8mf_dp - register file and ALU datapath
// Register file with valid bits, integer/logic/rotate ALU, minifloat adder
// and normaliser, and the output data register.
// ----------------------------------------------------------------------------
module alu8mf_dp #(
	parameter int unsigned REGISTER_COUNT = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  alu8mf_pkg::cmd_t                     cmd,
	input  logic [alu8mf_pkg::OP_W-1:0]          operation,
	input  logic [alu8mf_pkg::IDX_IN_W-1:0]      dest_reg,
	input  logic [alu8mf_pkg::IDX_IN_W-1:0]      src_a_reg,
	input  logic [alu8mf_pkg::IDX_IN_W-1:0]      src_b_reg,
	input  logic [alu8mf_pkg::CNT_W-1:0]         rotate_count,
	input  logic [alu8mf_pkg::DATA_W-1:0]        load_value,
	output logic [alu8mf_pkg::DATA_W-1:0]        result_value,
	output logic                                 overflow
);
	import alu8mf_pkg::*;

	localparam int unsigned IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

	// Register file: no reset on the array, a valid bit per entry instead
	logic [DATA_W-1:0]         mem_q [REGISTER_COUNT];
	logic [REGISTER_COUNT-1:0] vld_q;

	// Capture stage
	op_t                 op_s1;
	logic [IDX_IN_W-1:0] dest_s1;
	logic [2:0]          cnt_s1;
	logic [DATA_W-1:0]   ld_s1;
	logic [DATA_W-1:0]   rd_a_s1;
	logic [DATA_W-1:0]   rd_b_s1;

	// ALU stage
	op_t                 op_s2;
	logic [IDX_IN_W-1:0] dest_s2;
	logic [DATA_W-1:0]   res_s2;
	logic                ovf_s2;
	logic [FSUM_W-1:0]   fsum_s2;

	// Output register
	logic [DATA_W-1:0]   res_q;
	logic                ovf_q;

	logic [IDX_IN_W-1:0] rd_a_idx;
	logic                pres_a, pres_b, pres_d;

	logic [DATA_W-1:0]   alu_res;
	logic                alu_ovf;
	logic [DATA_W:0]     isum;
	logic [2*DATA_W-1:0] rot_w;
	logic [FSUM_W-1:0]   fval_a, fval_b;

	logic [FSUM_W-1:0]   fneg;
	logic [FMAG_W-1:0]   fmag;
	logic [2:0]          fexp;
	logic                fnorm;
	logic [FMAG_W-1:0]   fshift;
	logic [DATA_W-1:0]   fenc;
	logic                fovf;
	logic [DATA_W-1:0]   wb_val;
	logic                wb_ovf;
	logic                wb_we;

	// Index lies inside the populated part of the register file
	function automatic logic present(input logic [IDX_IN_W-1:0] idx);
		return 32'(idx) < REGISTER_COUNT;
	endfunction

	// Signed value of a minifloat byte in 2^-8 units
	function automatic logic [FSUM_W-1:0] mf_value(input logic [DATA_W-1:0] b);
		logic [FSUM_W-1:0] mag;
		mag = FSUM_W'(b[3:0]) << b[6:4];
		return b[7] ? (~mag + 1'b1) : mag;
	endfunction

	// Port A reads the destination for rotate and read
	assign rd_a_idx = (op_t'(operation) == OP_ROT || op_t'(operation) == OP_READ)
		? dest_reg : src_a_reg;
	assign pres_a = present(rd_a_idx);
	assign pres_b = present(src_b_reg);

	// Capture beat and read two operands
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1   <= op_t'(operation);
			dest_s1 <= dest_reg;
			cnt_s1  <= rotate_count[2:0];
			ld_s1   <= load_value;
			rd_a_s1 <= (pres_a && vld_q[rd_a_idx[IDX_W-1:0]])
				? mem_q[rd_a_idx[IDX_W-1:0]] : '0;
			rd_b_s1 <= (pres_b && vld_q[src_b_reg[IDX_W-1:0]])
				? mem_q[src_b_reg[IDX_W-1:0]] : '0;
		end
	end

	// ALU
	always_comb begin
		isum    = {rd_a_s1[DATA_W-1], rd_a_s1} + {rd_b_s1[DATA_W-1], rd_b_s1};
		rot_w   = {rd_a_s1, rd_a_s1} >> cnt_s1;
		fval_a  = mf_value(rd_a_s1);
		fval_b  = mf_value(rd_b_s1);
		alu_ovf = 1'b0;
		alu_res = '0;
		unique case (op_s1)
			OP_LOAD: alu_res = ld_s1;
			OP_ADD: begin
				alu_res = isum[DATA_W-1:0];
				alu_ovf = isum[DATA_W] ^ isum[DATA_W-1];
			end
			OP_FADD: alu_res = '0;
			OP_OR:   alu_res = rd_a_s1 | rd_b_s1;
			OP_AND:  alu_res = rd_a_s1 & rd_b_s1;
			OP_XOR:  alu_res = rd_a_s1 ^ rd_b_s1;
			OP_ROT:  alu_res = rot_w[DATA_W-1:0];
			OP_READ: alu_res = rd_a_s1;
			default: alu_res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.alu) begin
			op_s2   <= op_s1;
			dest_s2 <= dest_s1;
			res_s2  <= alu_res;
			ovf_s2  <= alu_ovf;
			fsum_s2 <= fval_a + fval_b;
		end
	end

	// Minifloat normalise and truncate: exponent from the leading one
	always_comb begin
		fneg  = ~fsum_s2 + 1'b1;
		fmag  = fsum_s2[FSUM_W-1] ? fneg[FMAG_W-1:0] : fsum_s2[FMAG_W-1:0];
		fexp  = '0;
		fnorm = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (fmag[i+3]) begin
				fexp  = 3'(i);
				fnorm = 1'b1;
			end
		end
		fovf   = fmag[FMAG_W-1];
		fshift = fmag >> fexp;
		// Zero and tiny sums flush to positive zero
		fenc   = fnorm ? {fsum_s2[FSUM_W-1], fexp, fshift[3:0]} : '0;
	end

	// Write-back selection
	always_comb begin
		pres_d = present(dest_s2);
		wb_ovf = (op_s2 == OP_FADD) ? fovf : ovf_s2;
		wb_val = (op_s2 == OP_FADD) ? fenc : res_s2;
		wb_we  = cmd.wb && !wb_ovf && (op_s2 != OP_READ) && pres_d;
	end

	// Register file array
	always_ff @(posedge clk) begin
		if (wb_we) begin
			mem_q[dest_s2[IDX_W-1:0]] <= wb_val;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wb_we) begin
			vld_q[dest_s2[IDX_W-1:0]] <= 1'b1;
		end
	end

	// Output data register
	always_ff @(posedge clk) begin
		if (cmd.wb) begin
			res_q <= (wb_ovf || !pres_d) ? '0 : wb_val;
			ovf_q <= wb_ovf;
		end
	end

	assign result_value = res_q;
	assign overflow     = ovf_q;

endmodule

// ----- src/alu8mf_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu8mf_chk - port checker for the execute unit
// Checks sequencing and result rules seen at the top-level channels.
// ----------------------------------------------------------------------------
module alu8mf_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] result_value,
	input logic       overflow
);

	// One instruction in flight: no beat taken straight after another
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("beat taken while an instruction is in flight");

	// Every beat produces its result once the ALU and write-back states have run
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |-> ##3 out_valid)
		else $error("result missing three cycles after beat");

	// An overflowing add reports a zero value
	a_ovf_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && overflow) |-> (result_value == 8'd0))
		else $error("overflow result with nonzero value");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
			(out_valid && $stable(result_value) && $stable(overflow)))
		else $error("stalled result changed");

endmodule

bind eight_bit_alu_with_minifloat_add alu8mf_chk u_alu8mf_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.result_value (out_ch.result_value),
	.overflow     (out_ch.overflow)
);
